@@ hdl/lhm_pkg.sv @@
// Shared types and constants for the linear probing hash map.
`timescale 1ns / 1ps
package lhm_pkg;
   localparam int TABLE_SIZE = 1024;
   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int KEY_W = 64;
   localparam int VAL_W = 64;
   localparam int CNT_W = 10;
   localparam int MAX_RESET = 768;

   localparam logic [1:0] ACT_FIND   = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_ERASE  = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_ZERO_KEY  = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [1:0]       action;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [VAL_W-1:0] value_out;
      logic [CNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic             key_we;
      logic             val_we;
      logic [IDX_W-1:0] waddr;
      logic [KEY_W-1:0] wkey;
      logic [VAL_W-1:0] wval;
      logic [IDX_W-1:0] raddr;
   } ram_ctl_type;

   typedef enum logic [2:0] {
      FSM_CLEAR, FSM_IDLE, FSM_PRD, FSM_PCHK, FSM_ERD, FSM_ECHK
   } fsm_type;
endpackage

@@ hdl/linear_probe_hash_map_top.sv @@
// Top level of the linear probing hash map with backward-shift deletion.
// Find and insert probe one bucket at a time, through a read state and a check state; the result is registered.
// Erase then scans on to the end of the cluster in the same way, shifting entries back.
// Zero keys and unused actions are answered in the cycle after the request.
// After reset the key memory is cleared bucket by bucket, with busy held high.
// One request is in flight at a time; results are strobed for one cycle, never held off.
`timescale 1ns / 1ps
module linear_probe_hash_map_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  lhm_pkg::req_type          req_payload,
   output logic                      rsp_strobe,
   output lhm_pkg::rsp_type          rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [lhm_pkg::CNT_W-1:0] csr_wr_data
);
   lhm_pkg::ram_ctl_type      ram_ctl;
   logic [lhm_pkg::KEY_W-1:0] rd_key;
   logic [lhm_pkg::VAL_W-1:0] rd_val;

   lhm_seq u_seq (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .ram_ctl(ram_ctl), .rd_key(rd_key), .rd_val(rd_val)
   );

   lhm_ram #(.WIDTH(lhm_pkg::KEY_W), .DEPTH(lhm_pkg::TABLE_SIZE)) u_key_ram (
      .clock(clock), .we(ram_ctl.key_we), .waddr(ram_ctl.waddr),
      .wdata(ram_ctl.wkey), .raddr(ram_ctl.raddr), .rdata(rd_key)
   );

   lhm_ram #(.WIDTH(lhm_pkg::VAL_W), .DEPTH(lhm_pkg::TABLE_SIZE)) u_val_ram (
      .clock(clock), .we(ram_ctl.val_we), .waddr(ram_ctl.waddr),
      .wdata(ram_ctl.wval), .raddr(ram_ctl.raddr), .rdata(rd_val)
   );
endmodule

@@ hdl/lhm_ram.sv @@
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module lhm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hdl/lhm_seq.sv @@
// Sequencer that walks probe chains and backward-shift deletions one bucket at a time.
`timescale 1ns / 1ps
module lhm_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lhm_pkg::req_type           req_payload,
   output logic                       rsp_strobe,
   output lhm_pkg::rsp_type           rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [lhm_pkg::CNT_W-1:0]  csr_wr_data,
   output lhm_pkg::ram_ctl_type       ram_ctl,
   input  logic [lhm_pkg::KEY_W-1:0]  rd_key,
   input  logic [lhm_pkg::VAL_W-1:0]  rd_val
);
   lhm_pkg::fsm_type                state_ff, state_in;
   lhm_pkg::req_type                req_ff, req_in;
   logic [lhm_pkg::IDX_W-1:0]       ptr_ff, ptr_in;
   logic [lhm_pkg::IDX_W-1:0]       hole_ff, hole_in;
   logic [lhm_pkg::CNT_W-1:0]       occ_ff, occ_in;
   logic [lhm_pkg::CNT_W-1:0]       max_ff;
   logic                            strobe_ff, strobe_in;
   lhm_pkg::rsp_type                rsp_ff, rsp_in;
   logic [31:0]                     lim;
   logic                            at_limit;
   logic [lhm_pkg::IDX_W-1:0]       home, off_hole, off_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lhm_pkg::FSM_CLEAR;
         ptr_ff    <= '0;
         occ_ff    <= '0;
         max_ff    <= lhm_pkg::CNT_W'(lhm_pkg::MAX_RESET);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         occ_ff    <= occ_in;
         strobe_ff <= strobe_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
      end
      req_ff  <= req_in;
      hole_ff <= hole_in;
      rsp_ff  <= rsp_in;
   end

   // At least one bucket always stays empty so every probe chain ends.
   assign lim = (32'(max_ff) > 32'(lhm_pkg::TABLE_SIZE - 1)) ?
                32'(lhm_pkg::TABLE_SIZE - 1) : 32'(max_ff);
   assign at_limit = (32'(occ_ff) + 32'd1) > lim;

   assign home     = rd_key[lhm_pkg::IDX_W-1:0];
   assign off_hole = hole_ff - home;
   assign off_cur  = ptr_ff - home;

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      ptr_in    = ptr_ff;
      hole_in   = hole_ff;
      occ_in    = occ_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      ram_ctl   = '{key_we: 1'b0, val_we: 1'b0, waddr: hole_ff, wkey: '0, wval: '0,
                    raddr: ptr_ff};
      unique case (state_ff)
         lhm_pkg::FSM_CLEAR: begin
            ram_ctl.key_we = 1'b1;
            ram_ctl.waddr  = ptr_ff;
            ptr_in         = ptr_ff + 1'b1;
            if (ptr_ff == lhm_pkg::IDX_W'(lhm_pkg::TABLE_SIZE - 1)) begin
               state_in = lhm_pkg::FSM_IDLE;
            end
         end
         lhm_pkg::FSM_IDLE: begin
            if (start) begin
               req_in = req_payload;
               ptr_in = req_payload.key[lhm_pkg::IDX_W-1:0];
               rsp_in = '{status: lhm_pkg::ST_NOT_FOUND, value_out: '0, entry_count: occ_ff};
               if (req_payload.action == lhm_pkg::ACT_UNUSED) begin
                  strobe_in = 1'b1;
               end else if (req_payload.key == '0) begin
                  rsp_in.status = lhm_pkg::ST_ZERO_KEY;
                  strobe_in     = 1'b1;
               end else begin
                  state_in = lhm_pkg::FSM_PRD;
               end
            end
         end
         lhm_pkg::FSM_PRD: begin
            state_in = lhm_pkg::FSM_PCHK;
         end
         lhm_pkg::FSM_PCHK: begin
            if (rd_key == req_ff.key) begin
               unique case (req_ff.action)
                  lhm_pkg::ACT_FIND: begin
                     rsp_in.status    = lhm_pkg::ST_OK;
                     rsp_in.value_out = rd_val;
                     strobe_in        = 1'b1;
                     state_in         = lhm_pkg::FSM_IDLE;
                  end
                  lhm_pkg::ACT_INSERT: begin
                     rsp_in.status = lhm_pkg::ST_DUPLICATE;
                     strobe_in     = 1'b1;
                     state_in      = lhm_pkg::FSM_IDLE;
                  end
                  default: begin
                     hole_in  = ptr_ff;
                     ptr_in   = ptr_ff + 1'b1;
                     state_in = lhm_pkg::FSM_ERD;
                  end
               endcase
            end else if (rd_key == '0) begin
               strobe_in = 1'b1;
               state_in  = lhm_pkg::FSM_IDLE;
               if (req_ff.action == lhm_pkg::ACT_INSERT) begin
                  if (at_limit) begin
                     rsp_in.status = lhm_pkg::ST_FULL;
                  end else begin
                     ram_ctl.key_we     = 1'b1;
                     ram_ctl.val_we     = 1'b1;
                     ram_ctl.waddr      = ptr_ff;
                     ram_ctl.wkey       = req_ff.key;
                     ram_ctl.wval       = req_ff.value;
                     occ_in             = occ_ff + 1'b1;
                     rsp_in.status      = lhm_pkg::ST_OK;
                     rsp_in.entry_count = occ_ff + 1'b1;
                  end
               end
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = lhm_pkg::FSM_PRD;
            end
         end
         lhm_pkg::FSM_ERD: begin
            state_in = lhm_pkg::FSM_ECHK;
         end
         lhm_pkg::FSM_ECHK: begin
            if (rd_key == '0) begin
               // End of the cluster: the hole left behind becomes empty.
               ram_ctl.key_we = 1'b1;
               if (occ_ff != '0) begin
                  occ_in             = occ_ff - 1'b1;
                  rsp_in.entry_count = occ_ff - 1'b1;
               end
               rsp_in.status = lhm_pkg::ST_OK;
               strobe_in     = 1'b1;
               state_in      = lhm_pkg::FSM_IDLE;
            end else begin
               if (off_hole < off_cur) begin
                  ram_ctl.key_we = 1'b1;
                  ram_ctl.val_we = 1'b1;
                  ram_ctl.wkey   = rd_key;
                  ram_ctl.wval   = rd_val;
                  hole_in        = ptr_ff;
               end
               ptr_in   = ptr_ff + 1'b1;
               state_in = lhm_pkg::FSM_ERD;
            end
         end
         default: begin
            state_in = lhm_pkg::FSM_IDLE;
         end
      endcase
   end

   assign busy        = (state_ff != lhm_pkg::FSM_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the linear probing hash map top level.
`timescale 1ns / 1ps
module testbench;
   localparam int CYCLE_LIMIT = 3000000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   lhm_pkg::req_type req_payload;
   logic rsp_strobe;
   lhm_pkg::rsp_type rsp_payload;
   logic csr_wr_en;
   logic [lhm_pkg::CNT_W-1:0] csr_wr_data;

   linear_probe_hash_map_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Shadow copy of the table, kept in step with accepted requests.
   logic [lhm_pkg::KEY_W-1:0] shadow_keys [lhm_pkg::TABLE_SIZE];
   logic [lhm_pkg::VAL_W-1:0] shadow_vals [lhm_pkg::TABLE_SIZE];
   logic [lhm_pkg::CNT_W-1:0] shadow_count;
   logic [lhm_pkg::CNT_W-1:0] shadow_max;

   lhm_pkg::req_type request_q [$];
   lhm_pkg::rsp_type answer_q [$];
   logic [lhm_pkg::KEY_W-1:0] key_pool [$];
   int errors;
   int answers_seen;
   int full_seen;
   int shifts_seen;
   int gap_left;
   bit allow_idle;
   longint unsigned cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [lhm_pkg::IDX_W-1:0] probe_bucket(logic [lhm_pkg::KEY_W-1:0] k);
      logic [lhm_pkg::IDX_W-1:0] b;
      b = k[lhm_pkg::IDX_W-1:0];
      for (int n = 0; n < lhm_pkg::TABLE_SIZE; n++) begin
         if (shadow_keys[b] == '0 || shadow_keys[b] == k) break;
         b = b + 1'b1;
      end
      return b;
   endfunction

   task automatic predict_answer(input lhm_pkg::req_type r);
      lhm_pkg::rsp_type e;
      logic [lhm_pkg::IDX_W-1:0] b, hole, nb, home, off_hole, off_cur;
      logic [lhm_pkg::CNT_W-1:0] lim;
      e.status = lhm_pkg::ST_NOT_FOUND;
      e.value_out = '0;
      lim = (shadow_max > lhm_pkg::TABLE_SIZE - 1) ?
            lhm_pkg::CNT_W'(lhm_pkg::TABLE_SIZE - 1) : shadow_max;
      if (r.action != lhm_pkg::ACT_UNUSED && r.key == '0) begin
         e.status = lhm_pkg::ST_ZERO_KEY;
      end else if (r.action == lhm_pkg::ACT_FIND) begin
         b = probe_bucket(r.key);
         if (shadow_keys[b] == r.key) begin
            e.status = lhm_pkg::ST_OK;
            e.value_out = shadow_vals[b];
         end
      end else if (r.action == lhm_pkg::ACT_INSERT) begin
         b = probe_bucket(r.key);
         if (shadow_keys[b] == r.key) begin
            e.status = lhm_pkg::ST_DUPLICATE;
         end else if (shadow_keys[b] != '0 || 11'(shadow_count) + 11'd1 > 11'(lim)) begin
            e.status = lhm_pkg::ST_FULL;
            full_seen++;
         end else begin
            shadow_keys[b] = r.key;
            shadow_vals[b] = r.value;
            shadow_count++;
            e.status = lhm_pkg::ST_OK;
         end
      end else if (r.action == lhm_pkg::ACT_ERASE) begin
         hole = probe_bucket(r.key);
         if (shadow_keys[hole] == r.key) begin
            nb = hole + 1'b1;
            for (int n = 0; n < lhm_pkg::TABLE_SIZE && shadow_keys[nb] != '0; n++) begin
               home = shadow_keys[nb][lhm_pkg::IDX_W-1:0];
               off_hole = hole - home;
               off_cur = nb - home;
               if (off_hole < off_cur) begin
                  shadow_keys[hole] = shadow_keys[nb];
                  shadow_vals[hole] = shadow_vals[nb];
                  hole = nb;
                  shifts_seen++;
               end
               nb = nb + 1'b1;
            end
            shadow_keys[hole] = '0;
            shadow_vals[hole] = '0;
            if (shadow_count > 0) shadow_count--;
            e.status = lhm_pkg::ST_OK;
         end
      end
      e.entry_count = shadow_count;
      answer_q.push_back(e);
   endtask

   // Driver: presents queued requests, with random bursts of idle cycles while allow_idle is set.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_payload <= '0;
         gap_left = 0;
      end else begin
         if (start && !busy) predict_answer(req_payload);
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (request_q.size() > 0 && allow_idle && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 3);
               start <= 1'b0;
            end else if (request_q.size() > 0) begin
               req_payload <= request_q.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      lhm_pkg::rsp_type e;
      if (!reset && rsp_strobe) begin
         answers_seen++;
         if (answer_q.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
         end else begin
            e = answer_q.pop_front();
            if (rsp_payload.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_payload.status);
               errors++;
            end
            if (rsp_payload.value_out !== e.value_out) begin
               $error("value_out: expected %h, got %h", e.value_out, rsp_payload.value_out);
               errors++;
            end
            if (rsp_payload.entry_count !== e.entry_count) begin
               $error("entry_count: expected %0d, got %0d", e.entry_count,
                      rsp_payload.entry_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL linear_probe_hash_map_top");
         $finish;
      end
   end

   function automatic logic [lhm_pkg::KEY_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_request(logic [1:0] act, logic [lhm_pkg::KEY_W-1:0] k,
                               logic [lhm_pkg::VAL_W-1:0] v);
      lhm_pkg::req_type r;
      r.action = act;
      r.key = k;
      r.value = v;
      request_q.push_back(r);
   endtask

   task automatic wait_idle();
      while (request_q.size() > 0 || answer_q.size() > 0 || start || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic [lhm_pkg::CNT_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      shadow_max = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Keys are drawn from small clusters of home buckets so that probes collide.
   task automatic fill_pool(int size);
      logic [lhm_pkg::IDX_W-1:0] base;
      logic [lhm_pkg::KEY_W-1:0] k;
      key_pool.delete();
      for (int i = 0; i < size; i++) begin
         if (i % 16 == 0) begin
            case ($urandom_range(0, 2))
               0: base = '0;
               1: base = lhm_pkg::IDX_W'(lhm_pkg::TABLE_SIZE - 5);
               default: base = lhm_pkg::IDX_W'($urandom);
            endcase
         end
         k = rand64();
         k[lhm_pkg::IDX_W-1:0] = base + lhm_pkg::IDX_W'($urandom_range(0, 7));
         if (k == '0) k = 64'h400;
         key_pool.push_back(k);
      end
   endtask

   task automatic random_phase(int count, int pool_size);
      int pick;
      logic [lhm_pkg::KEY_W-1:0] k;
      fill_pool(pool_size);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         if (pick < 40) push_request(lhm_pkg::ACT_INSERT, k, rand64());
         else if (pick < 70) push_request(lhm_pkg::ACT_FIND, k, rand64());
         else if (pick < 94) push_request(lhm_pkg::ACT_ERASE, k, rand64());
         else if (pick < 96) push_request(2'($urandom_range(0, 2)), '0, rand64());
         else if (pick < 98) push_request(lhm_pkg::ACT_UNUSED, rand64(), rand64());
         else push_request(2'($urandom_range(0, 2)), rand64(), rand64());
      end
   endtask

   initial begin
      foreach (shadow_keys[i]) begin
         shadow_keys[i] = '0;
         shadow_vals[i] = '0;
      end
      shadow_count = '0;
      shadow_max = lhm_pkg::CNT_W'(lhm_pkg::MAX_RESET);
      errors = 0;
      answers_seen = 0;
      full_seen = 0;
      shifts_seen = 0;
      cycles = 0;
      allow_idle = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // Directed requests at the reset limit: extremes, wrap-around and zero keys.
      push_request(lhm_pkg::ACT_INSERT, '1, '1);
      push_request(lhm_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, '0);
      push_request(lhm_pkg::ACT_INSERT, 64'h1, 64'h5555_5555_5555_5555);
      push_request(lhm_pkg::ACT_INSERT, 64'h3FF, 64'hAAAA_AAAA_AAAA_AAAA);
      push_request(lhm_pkg::ACT_INSERT, 64'h7FF, 64'h0123_4567_89AB_CDEF);
      push_request(lhm_pkg::ACT_INSERT, 64'hC00, 64'hFEDC_BA98_7654_3210);
      push_request(lhm_pkg::ACT_FIND, '1, '0);
      push_request(lhm_pkg::ACT_FIND, 64'h7FF, '1);
      push_request(lhm_pkg::ACT_FIND, 64'hC00, '0);
      push_request(lhm_pkg::ACT_INSERT, 64'h3FF, '1);
      push_request(lhm_pkg::ACT_FIND, 64'h2, '0);
      push_request(lhm_pkg::ACT_ERASE, 64'h2, '0);
      push_request(lhm_pkg::ACT_ERASE, '1, '0);
      push_request(lhm_pkg::ACT_FIND, 64'h7FF, '0);
      push_request(lhm_pkg::ACT_FIND, 64'hC00, '0);
      push_request(lhm_pkg::ACT_FIND, 64'h8000_0000_0000_0000, '0);
      push_request(lhm_pkg::ACT_FIND, '0, '1);
      push_request(lhm_pkg::ACT_INSERT, '0, '1);
      push_request(lhm_pkg::ACT_ERASE, '0, '1);
      push_request(lhm_pkg::ACT_UNUSED, 64'h3FF, '1);
      push_request(lhm_pkg::ACT_ERASE, 64'h3FF, '0);
      push_request(lhm_pkg::ACT_FIND, 64'h1, '0);
      wait_idle();

      // A limit of one: nearly every insert is refused, duplicates still reported.
      write_limit(lhm_pkg::CNT_W'(1));
      push_request(lhm_pkg::ACT_INSERT, 64'h1, '0);
      push_request(lhm_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, '0);
      random_phase(60, 16);
      wait_idle();

      write_limit(lhm_pkg::CNT_W'(20));
      random_phase(380, 40);
      wait_idle();

      write_limit(lhm_pkg::CNT_W'(lhm_pkg::TABLE_SIZE - 1));
      random_phase(400, 96);
      wait_idle();

      // Final stretch runs back to back with no idle cycles.
      allow_idle = 1'b0;
      write_limit(lhm_pkg::CNT_W'(40));
      random_phase(390, 64);
      wait_idle();
      repeat (20) @(posedge clock);

      $display("Checked %0d results over limits 768, 1, 20, 1023 and 40.", answers_seen);
      $display("Saw %0d refusals for a full table and %0d backward shifts.",
               full_seen, shifts_seen);
      if (errors == 0 && answer_q.size() == 0) begin
         $display("PASS linear_probe_hash_map_top");
      end else begin
         $display("FAIL linear_probe_hash_map_top");
      end
      $finish;
   end
endmodule

@@ files.f @@
hdl/lhm_pkg.sv
hdl/lhm_ram.sv
hdl/lhm_seq.sv
hdl/linear_probe_hash_map_top.sv
tb/sv/testbench.sv
